/* rtl/core/tzs_pkg.sv */
`timescale 1ns / 1ps
// tzs_pkg: shared constants, word types and helpers of the triangle z-plane slicer
// depends on nothing; used by every module under rtl/core

package tzs_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int PROD_W     = COORD_W + QUO_W;
   localparam int NUM_LANES  = 3;
   localparam int LANE_IDX_W = 2;
   localparam int ITEM_GAP   = 3;
   localparam int GAP_W      = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [COORD_W-1:0]        mag_type;
   typedef logic [COORD_W:0]          diff_type;
   typedef logic [QUO_W-1:0]          quo_type;
   typedef logic [NUM_LANES-1:0]      lane_mask_type;

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type a_z;
      coord_type b_x;
      coord_type b_y;
      coord_type b_z;
      coord_type c_x;
      coord_type c_y;
      coord_type c_z;
   } req_word_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      last_point;
   } rsp_word_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      vertex_type s;
      vertex_type e;
   } edge_type;

   // what travels beside the divider: hit flag, start point and per-axis span
   typedef struct packed {
      logic      hit;
      coord_type s_x;
      coord_type s_y;
      coord_type s_z;
      mag_type   m_x;
      mag_type   m_y;
      mag_type   m_z;
      logic      neg_x;
      logic      neg_y;
      logic      neg_z;
   } lerp_side_type;

   typedef struct packed {
      logic      hit;
      coord_type x;
      coord_type y;
      coord_type z;
   } lane_res_type;

   // magnitude of a 33-bit difference of two coordinates, fits 32 bits
   function automatic mag_type mag_of(diff_type d);
      diff_type n;
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   function automatic diff_type sub_ext(coord_type a, coord_type b);
      return {a[COORD_W-1], a} - {b[COORD_W-1], b};
   endfunction

endpackage

/* rtl/core/tzs_div.sv */
`timescale 1ns / 1ps
// tzs_div: pipelined restoring divider, one quotient bit per stage, with sideband
// depends on tzs_pkg

module tzs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tzs_pkg::mag_type      in_num,
   input  tzs_pkg::mag_type      in_den,
   input  tzs_pkg::lerp_side_type in_side,
   output logic                  out_valid,
   output tzs_pkg::quo_type      out_quo,
   output tzs_pkg::lerp_side_type out_side
);
   import tzs_pkg::*;

   logic          vld_ff  [QUO_W];
   mag_type       rem_ff  [QUO_W];
   mag_type       den_ff  [QUO_W];
   quo_type       quo_ff  [QUO_W];
   lerp_side_type side_ff [QUO_W];

   logic          src_vld  [QUO_W];
   mag_type       src_rem  [QUO_W];
   mag_type       src_den  [QUO_W];
   quo_type       src_quo  [QUO_W];
   lerp_side_type src_side [QUO_W];

   mag_type       rem_in [QUO_W];
   quo_type       quo_in [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_src
      if (k == 0) begin : g_head
         assign src_vld[k]  = in_valid;
         assign src_rem[k]  = in_num;
         assign src_den[k]  = in_den;
         assign src_quo[k]  = '0;
         assign src_side[k] = in_side;
      end else begin : g_body
         assign src_vld[k]  = vld_ff[k-1];
         assign src_rem[k]  = rem_ff[k-1];
         assign src_den[k]  = den_ff[k-1];
         assign src_quo[k]  = quo_ff[k-1];
         assign src_side[k] = side_ff[k-1];
      end
   end

   // first stage takes the integer bit (num >= den), the rest shift in fraction bits
   always_comb begin : p_step
      logic [COORD_W:0] trial;
      logic [COORD_W:0] diff;
      logic             ge;
      for (int k = 0; k < QUO_W; k++) begin
         trial = (k == 0) ? {1'b0, src_rem[k]} : {src_rem[k], 1'b0};
         diff  = trial - {1'b0, src_den[k]};
         ge    = (trial >= {1'b0, src_den[k]});
         rem_in[k] = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         quo_in[k] = {src_quo[k][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld[k];
         end
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= src_den[k];
         quo_ff[k]  <= quo_in[k];
         side_ff[k] <= src_side[k];
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

/* rtl/core/tzs_lane.sv */
`timescale 1ns / 1ps
// tzs_lane: one edge of the triangle against the plane: range test, divide, interpolate
// depends on tzs_pkg and tzs_div

module tzs_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tzs_pkg::edge_type     in_edge,
   input  tzs_pkg::coord_type    plane_height,
   output tzs_pkg::lane_res_type out_res
);
   import tzs_pkg::*;

   // stage a: differences
   logic       a_vld_ff;
   vertex_type a_s_ff;
   diff_type   a_num_ff, a_dx_ff, a_dy_ff, a_dz_ff;

   // stage b: magnitudes and sign test
   logic          b_vld_ff;
   mag_type       b_an_ff, b_ad_ff;
   lerp_side_type b_side_ff, b_side_in;

   // stage c: t within [0,1]
   logic          c_vld_ff;
   mag_type       c_an_ff, c_ad_ff;
   lerp_side_type c_side_ff, c_side_in;

   logic          d_vld;
   quo_type       d_quo;
   lerp_side_type d_side;

   // stage m: scaled offsets
   logic          m_vld_ff;
   lerp_side_type m_side_ff;
   mag_type       m_off_x_ff, m_off_y_ff, m_off_z_ff;
   mag_type       m_off_x_in, m_off_y_in, m_off_z_in;
   logic [PROD_W-1:0] prod_x, prod_y, prod_z;

   // stage p: point
   logic       p_hit_ff;
   vertex_type p_pt_ff, p_pt_in;

   always_comb begin
      b_side_in.hit   = (a_dz_ff != '0) &&
                        ((a_num_ff == '0) || (a_num_ff[COORD_W] == a_dz_ff[COORD_W]));
      b_side_in.s_x   = a_s_ff.x;
      b_side_in.s_y   = a_s_ff.y;
      b_side_in.s_z   = a_s_ff.z;
      b_side_in.m_x   = mag_of(a_dx_ff);
      b_side_in.m_y   = mag_of(a_dy_ff);
      b_side_in.m_z   = mag_of(a_dz_ff);
      b_side_in.neg_x = a_dx_ff[COORD_W];
      b_side_in.neg_y = a_dy_ff[COORD_W];
      b_side_in.neg_z = a_dz_ff[COORD_W];
   end

   always_comb begin
      c_side_in     = b_side_ff;
      c_side_in.hit = b_side_ff.hit && (b_an_ff <= b_ad_ff);
   end

   tzs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_num    (c_an_ff),
      .in_den    (c_ad_ff),
      .in_side   (c_side_ff),
      .out_valid (d_vld),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   always_comb begin
      prod_x = {{QUO_W{1'b0}}, d_side.m_x} * {{COORD_W{1'b0}}, d_quo};
      prod_y = {{QUO_W{1'b0}}, d_side.m_y} * {{COORD_W{1'b0}}, d_quo};
      prod_z = {{QUO_W{1'b0}}, d_side.m_z} * {{COORD_W{1'b0}}, d_quo};
      // t <= 1 keeps each offset within its span
      m_off_x_in = prod_x[FRAC_BITS +: COORD_W];
      m_off_y_in = prod_y[FRAC_BITS +: COORD_W];
      m_off_z_in = prod_z[FRAC_BITS +: COORD_W];
   end

   always_comb begin
      p_pt_in.x = m_side_ff.neg_x ? m_side_ff.s_x - $signed(m_off_x_ff)
                                  : m_side_ff.s_x + $signed(m_off_x_ff);
      p_pt_in.y = m_side_ff.neg_y ? m_side_ff.s_y - $signed(m_off_y_ff)
                                  : m_side_ff.s_y + $signed(m_off_y_ff);
      p_pt_in.z = m_side_ff.neg_z ? m_side_ff.s_z - $signed(m_off_z_ff)
                                  : m_side_ff.s_z + $signed(m_off_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         p_hit_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         m_vld_ff <= d_vld;
         p_hit_ff <= m_vld_ff && m_side_ff.hit;
      end
      a_s_ff     <= in_edge.s;
      a_num_ff   <= sub_ext(plane_height, in_edge.s.z);
      a_dx_ff    <= sub_ext(in_edge.e.x, in_edge.s.x);
      a_dy_ff    <= sub_ext(in_edge.e.y, in_edge.s.y);
      a_dz_ff    <= sub_ext(in_edge.e.z, in_edge.s.z);
      b_an_ff    <= mag_of(a_num_ff);
      b_ad_ff    <= mag_of(a_dz_ff);
      b_side_ff  <= b_side_in;
      c_an_ff    <= b_an_ff;
      c_ad_ff    <= b_ad_ff;
      c_side_ff  <= c_side_in;
      m_side_ff  <= d_side;
      m_off_x_ff <= m_off_x_in;
      m_off_y_ff <= m_off_y_in;
      m_off_z_ff <= m_off_z_in;
      p_pt_ff    <= p_pt_in;
   end

   assign out_res.hit = p_hit_ff;
   assign out_res.x   = p_pt_ff.x;
   assign out_res.y   = p_pt_ff.y;
   assign out_res.z   = p_pt_ff.z;

endmodule

/* rtl/core/tzs_merge.sv */
`timescale 1ns / 1ps
// tzs_merge: collects the three lane results of a triangle and sends the hits in edge order
// depends on tzs_pkg

module tzs_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  tzs_pkg::lane_res_type [tzs_pkg::NUM_LANES-1:0] lane_res,
   output logic                                         rsp_strobe,
   output tzs_pkg::rsp_word_type                        rsp_word
);
   import tzs_pkg::*;

   lane_mask_type hits, mask, rest, pend_ff, pend_in;
   lane_res_type [NUM_LANES-1:0] buf_ff, buf_in, src;
   logic [LANE_IDX_W-1:0] sel;
   logic         strobe_ff, strobe_in;
   rsp_word_type word_ff, word_in;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         hits[i] = lane_res[i].hit;
      end
      // a new triangle only shows up once the previous one has drained
      mask   = hits | pend_ff;
      src    = (hits != '0) ? lane_res : buf_ff;
      buf_in = src;
      sel    = '0;
      for (int i = NUM_LANES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            sel = LANE_IDX_W'(i);
         end
      end
      rest    = mask & ~(lane_mask_type'(1) << sel);
      pend_in = rest;
      strobe_in          = (mask != '0);
      word_in.point_x    = src[sel].x;
      word_in.point_y    = src[sel].y;
      word_in.point_z    = src[sel].z;
      word_in.last_point = (rest == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      buf_ff  <= buf_in;
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule

/* rtl/core/triangle_zplane_slicer_top.sv */
`timescale 1ns / 1ps
// triangle_zplane_slicer_top: slices triangles against the plane z = plane height
// depends on tzs_pkg, tzs_lane (with tzs_div) and tzs_merge
//
//   channel   ports                          direction   transfer
//   request   start, busy, req_word          in          start high while busy low
//   response  rsp_strobe, rsp_word           out         one cycle per word, no stall
//   csr       csr_wr_en, csr_wr_data         in          every cycle csr_wr_en is high
//
// busy holds off a new triangle after a take: the response port moves one point a cycle
// and a triangle gives up to three, which the merge must send before the next arrives
// the first point of a triangle reaches the response port through these registers:
// 3 prep stages, 17 divider stages (one quotient bit each), multiply, point, merge
// the remaining points follow on the next cycles without gaps; last_point marks the end
// reset is synchronous and clears the plane height to 0 and all valid and pending flags
// the receiver cannot stall; the merge always drains a triangle before the next arrives

module triangle_zplane_slicer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tzs_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output tzs_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  tzs_pkg::coord_type    csr_wr_data
);
   import tzs_pkg::*;

   logic              accept;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   coord_type         plane_height_ff;
   edge_type     [NUM_LANES-1:0] edges;
   lane_res_type [NUM_LANES-1:0] lane_res;

   assign busy   = (gap_ff != '0);
   assign accept = start && !busy;

   // spacing counter: holds off the next triangle until the merge has room
   always_comb begin
      if (accept) begin
         gap_in = GAP_W'(ITEM_GAP - 1);
      end else if (busy) begin
         gap_in = gap_ff - 1'b1;
      end else begin
         gap_in = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff          <= '0;
         plane_height_ff <= '0;
      end else begin
         gap_ff <= gap_in;
         if (csr_wr_en) begin
            plane_height_ff <= csr_wr_data;
         end
      end
   end

   // edges a->b, b->c, c->a, one per lane
   always_comb begin
      edges[0].s = '{x: req_word.a_x, y: req_word.a_y, z: req_word.a_z};
      edges[0].e = '{x: req_word.b_x, y: req_word.b_y, z: req_word.b_z};
      edges[1].s = '{x: req_word.b_x, y: req_word.b_y, z: req_word.b_z};
      edges[1].e = '{x: req_word.c_x, y: req_word.c_y, z: req_word.c_z};
      edges[2].s = '{x: req_word.c_x, y: req_word.c_y, z: req_word.c_z};
      edges[2].e = '{x: req_word.a_x, y: req_word.a_y, z: req_word.a_z};
   end

   // all lanes run in lockstep so their results reach the merge together
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      tzs_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (accept),
         .in_edge      (edges[i]),
         .plane_height (plane_height_ff),
         .out_res      (lane_res[i])
      );
   end

   tzs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_res   (lane_res),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

/* rtl/core/tzs_checker.sv */
`timescale 1ns / 1ps
// tzs_checker: port-level checks of spacing and point sequencing of the slicer top
// depends on tzs_pkg; bound to triangle_zplane_slicer_top below

module tzs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input tzs_pkg::rsp_word_type rsp_word
);
   import tzs_pkg::*;

   // a take keeps busy high for the hold-off that follows
   a_gap : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy)
      else $error("busy not held after a take");

   // busy only rises after a take
   a_busy_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a take");

   // points of one triangle come back to back
   a_no_hole : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last_point) |=> rsp_strobe)
      else $error("gap inside a triangle's points");

   // at most three points per triangle
   a_max_three : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last_point &&
       $past(rsp_strobe && !rsp_word.last_point)) |=> (rsp_strobe && rsp_word.last_point))
      else $error("more than three points in a triangle");

endmodule

bind triangle_zplane_slicer_top tzs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

/* bench/tb_triangle_zplane_slicer_top.sv */
`timescale 1ns / 1ps
// tb_triangle_zplane_slicer_top: self-checking bench for the triangle z-plane slicer
// depends on tzs_pkg and triangle_zplane_slicer_top; predicts crossing points per triangle

module tb_triangle_zplane_slicer_top;

   import tzs_pkg::*;

   // long enough for a full pass from the take to the first point, plus margin
   localparam int SETTLE_CYCLES = 30;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int PHASE_ITEMS   = 100;
   localparam int NUM_PHASES    = 5;

   localparam longint   Z_MAX = 64'sd2147483647;
   localparam longint   Z_MIN = -64'sd2147483648;
   localparam coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam coord_type ONE   = 32'sh0001_0000;

   // what the driver pulls off its queue: a triangle, a plane write, or a full drain
   typedef enum logic [1:0] {
      SEQ_TRIANGLE,
      SEQ_PLANE,
      SEQ_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_word_type  word;
      coord_type     height;
      int            gap;
   } step_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         start       = 1'b0;
   logic         busy;
   req_word_type req_word    = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_wr_en   = 1'b0;
   coord_type    csr_wr_data = '0;

   step_type     pending_steps[$];
   rsp_word_type expected_points[$];
   coord_type    plane_shadow = '0;   // plane height as the block should hold it
   bit           gaps_on = 1'b1;
   int           wait_cycles = 0;     // cycles since the sender last raised start
   int           idle_cycles = 0;     // cycles with neither a take nor a response word
   int           mismatch_count = 0;
   int           cycle_count = 0;

   triangle_zplane_slicer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // append to the tail of the step queue
   function automatic void add_step(step_type st);
      pending_steps.insert(pending_steps.size(), st);
   endfunction

   // append to the tail of the prediction queue
   function automatic void add_point(rsp_word_type pt);
      expected_points.insert(expected_points.size(), pt);
   endfunction

   // one axis of S + (E - S) * t, offset truncated toward zero
   function automatic coord_type lerp_axis(longint s, longint e, longint tq);
      longint d;
      longint m;
      d = e - s;
      m = ((d < 0 ? -d : d) * tq) >>> FRAC_BITS;
      return coord_type'(d < 0 ? s - m : s + m);
   endfunction

   // expected crossing points of one triangle against the current plane
   function automatic void slice_triangle(req_word_type w, coord_type plane);
      longint       vx[3];
      longint       vy[3];
      longint       vz[3];
      longint       dz;
      longint       num;
      longint       an;
      longint       ad;
      longint       tq;
      rsp_word_type found[3];
      int           cnt;
      int           nx;
      cnt = 0;
      vx[0] = w.a_x; vy[0] = w.a_y; vz[0] = w.a_z;
      vx[1] = w.b_x; vy[1] = w.b_y; vz[1] = w.b_z;
      vx[2] = w.c_x; vy[2] = w.c_y; vz[2] = w.c_z;
      for (int k = 0; k < 3; k++) begin
         nx  = (k + 1) % 3;
         dz  = vz[nx] - vz[k];
         num = longint'(plane) - vz[k];
         // flat edge gives nothing, even when it lies in the plane
         if (dz == 0) continue;
         // plane on the far side of the start vertex
         if (num != 0 && ((num < 0) != (dz < 0))) continue;
         an = num < 0 ? -num : num;
         ad = dz < 0 ? -dz : dz;
         // plane beyond the end vertex
         if (an > ad) continue;
         tq = (an << FRAC_BITS) / ad;
         found[cnt].point_x    = lerp_axis(vx[k], vx[nx], tq);
         found[cnt].point_y    = lerp_axis(vy[k], vy[nx], tq);
         found[cnt].point_z    = lerp_axis(vz[k], vz[nx], tq);
         found[cnt].last_point = 1'b0;
         cnt++;
      end
      if (cnt > 0) found[cnt-1].last_point = 1'b1;
      for (int k = 0; k < cnt; k++) add_point(found[k]);
   endfunction

   // mostly no gap, some short ones, a few long ones, none at all when gaps are off
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 19);
      if (!gaps_on || r < 12) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic void queue_triangle(coord_type ax, coord_type ay, coord_type az,
                                          coord_type bx, coord_type by, coord_type bz,
                                          coord_type cx, coord_type cy, coord_type cz);
      step_type st;
      st.kind   = SEQ_TRIANGLE;
      st.word   = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      st.height = '0;
      st.gap    = next_gap();
      add_step(st);
   endfunction

   function automatic void queue_plane(coord_type h);
      step_type st;
      st.kind   = SEQ_PLANE;
      st.word   = '0;
      st.height = h;
      st.gap    = 0;
      add_step(st);
   endfunction

   function automatic void queue_drain();
      step_type st;
      st.kind   = SEQ_DRAIN;
      st.word   = '0;
      st.height = '0;
      st.gap    = 0;
      add_step(st);
   endfunction

   // a z near the plane at a random scale, sometimes on it, sometimes anywhere
   function automatic coord_type near_plane(coord_type h);
      longint v;
      case ($urandom_range(0, 11))
         0: return h;
         1: return coord_type'($urandom);
         default: begin
            v = longint'($urandom >> $urandom_range(0, 31));
            if ($urandom_range(0, 1)) v = -v;
            v = v + longint'(h);
            if (v > Z_MAX) v = Z_MAX;
            if (v < Z_MIN) v = Z_MIN;
            return coord_type'(v);
         end
      endcase
   endfunction

   // sender: takes happen when start is high and busy low; plane writes and drains
   // wait until every expected word is back and the pipe has had time to empty
   always @(posedge clock) begin
      logic drive_start;
      logic drive_wr;
      drive_start = start;
      drive_wr    = 1'b0;
      if (reset) begin
         drive_start = 1'b0;
         wait_cycles = 0;
         idle_cycles = 0;
      end else begin
         if (rsp_strobe === 1'b1) idle_cycles = 0;
         else if (idle_cycles < 1000) idle_cycles++;
         if (start && !busy) begin
            slice_triangle(req_word, plane_shadow);
            idle_cycles = 0;
            drive_start = 1'b0;
         end
         if (!drive_start) begin
            if (pending_steps.size() > 0) begin
               case (pending_steps[0].kind)
                  SEQ_TRIANGLE: begin
                     if (wait_cycles >= pending_steps[0].gap) begin
                        req_word    <= pending_steps[0].word;
                        drive_start = 1'b1;
                        wait_cycles = 0;
                        void'(pending_steps.pop_front());
                     end else begin
                        wait_cycles++;
                     end
                  end
                  default: begin
                     if (expected_points.size() == 0 && idle_cycles >= SETTLE_CYCLES) begin
                        if (pending_steps[0].kind == SEQ_PLANE) begin
                           drive_wr     = 1'b1;
                           csr_wr_data  <= pending_steps[0].height;
                           plane_shadow = pending_steps[0].height;
                        end
                        void'(pending_steps.pop_front());
                     end
                     wait_cycles++;
                  end
               endcase
            end else begin
               wait_cycles++;
            end
         end
      end
      start     <= drive_start;
      csr_wr_en <= drive_wr;
   end

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %h want %h", name, got, want));
   endtask

   // receiver: every strobed word is taken and matched against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_points.size() == 0) begin
            flag_error($sformatf("unexpected point %h %h %h last %b", rsp_word.point_x,
                                 rsp_word.point_y, rsp_word.point_z, rsp_word.last_point));
         end else begin
            want = expected_points.pop_front();
            check_field("point_x", rsp_word.point_x, want.point_x);
            check_field("point_y", rsp_word.point_y, want.point_y);
            check_field("point_z", rsp_word.point_z, want.point_z);
            check_field("last_point", 32'(rsp_word.last_point), 32'(want.last_point));
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
                  expected_points.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      coord_type phase_height[NUM_PHASES];
      coord_type az;
      coord_type bz;
      coord_type cz;
      int        settle;

      // directed part, plane at its reset value of zero
      queue_triangle(ONE, 2*ONE, -ONE, 3*ONE, 4*ONE, ONE, 5*ONE, 6*ONE, 2*ONE);
      // fully flat in the plane, then missed above and below
      queue_triangle(ONE, ONE, 0, -ONE, 3*ONE, 0, 7*ONE, -ONE, 0);
      queue_triangle(0, 0, ONE, ONE, 0, 2*ONE, 0, ONE, 3*ONE);
      queue_triangle(0, 0, -ONE, ONE, 0, -2*ONE, 0, ONE, -3*ONE);
      // vertex on the plane: shows up twice, plus the opposite crossing
      queue_triangle(ONE, ONE, 0, 2*ONE, -ONE, ONE, -3*ONE, 5*ONE, -ONE);
      // edge lying in the plane is skipped, the other two touch its ends
      queue_triangle(ONE, 2*ONE, 0, 3*ONE, 4*ONE, 0, 5*ONE, 6*ONE, ONE);
      // coordinate extremes
      queue_triangle(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX);
      queue_triangle(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0, 1);
      // one-third crossing, quotient truncation
      queue_triangle(C_MAX, 3, -1, C_MIN, -7, 2, 100, 200, 3);
      queue_triangle(5, 6, -1, 7, 8, -1, 9, 10, -1);
      // end vertex exactly on the plane
      queue_triangle(0, 0, -3, ONE, ONE, 0, -ONE, 2*ONE, -5);

      queue_plane(C_MAX);
      queue_triangle(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0, 0);
      queue_triangle(1, 2, C_MAX, 3, 4, C_MAX, 5, 6, C_MAX);
      queue_triangle(C_MAX, C_MAX, C_MAX - 1, C_MIN, C_MIN, C_MAX, 0, -1, C_MIN);

      queue_plane(C_MIN);
      queue_triangle(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, -1, -1, C_MIN + 1);
      queue_triangle(1, 2, C_MIN, 3, 4, C_MIN, 5, 6, C_MIN);
      queue_triangle(C_MIN, C_MAX, C_MIN + 5, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN + 3);

      queue_plane(32'sh0000_8000);
      queue_triangle(-ONE, ONE, 0, ONE, -ONE, ONE, 0, 0, 32'sh0000_8000);
      queue_drain();

      // random phases, each with its own plane height; the middle one runs without gaps
      phase_height[0] = $urandom;
      phase_height[1] = C_MAX;
      phase_height[2] = coord_type'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      phase_height[3] = C_MIN;
      phase_height[4] = $urandom;
      for (int p = 0; p < NUM_PHASES; p++) begin
         queue_plane(phase_height[p]);
         gaps_on = (p != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) queue_drain();
            az = near_plane(phase_height[p]);
            bz = near_plane(phase_height[p]);
            cz = near_plane(phase_height[p]);
            // now and then a flat edge
            case ($urandom_range(0, 15))
               0: bz = az;
               1: cz = bz;
               2: az = cz;
               default: ;
            endcase
            queue_triangle($urandom, $urandom, az, $urandom, $urandom, bz,
                           $urandom, $urandom, cz);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all stimulus taken, then let the pipe empty
      while (pending_steps.size() != 0 || start) @(posedge clock);
      settle = 0;
      while ((expected_points.size() != 0 || idle_cycles < SETTLE_CYCLES) &&
             settle < DRAIN_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      if (expected_points.size() != 0)
         flag_error($sformatf("%0d points never arrived", expected_points.size()));

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* triangle_zplane_slicer_top.f */
rtl/core/tzs_pkg.sv
rtl/core/tzs_div.sv
rtl/core/tzs_lane.sv
rtl/core/tzs_merge.sv
rtl/core/triangle_zplane_slicer_top.sv
rtl/core/tzs_checker.sv
bench/tb_triangle_zplane_slicer_top.sv
